// File: hdl/transition_trace_overwrite_queue_unit_defines.svh
// Assertion macros shared by the trace queue RTL.
`ifndef TRANSITION_TRACE_OVERWRITE_QUEUE_UNIT_DEFINES_SVH
`define TRANSITION_TRACE_OVERWRITE_QUEUE_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define TTOQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define TTOQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hdl/ttoq_pkg.sv
package ttoq_pkg;

  localparam int unsigned StateBits = 4;
  localparam int unsigned StampBits = 32;
  localparam int unsigned DropBits  = 32;

  typedef enum logic [1:0] {
    OpPush  = 2'd0,
    OpPop   = 2'd1,
    OpClear = 2'd2,
    OpNop   = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [StateBits-1:0]   prev_state_in;
    logic [StateBits-1:0]   cur_state_in;
    logic [StampBits-1:0]   stamp_in;
  } req_t;

  typedef struct packed {
    logic                   pop_valid;
    logic [StateBits-1:0]   prev_state_out;
    logic [StateBits-1:0]   cur_state_out;
    logic [StampBits-1:0]   stamp_out;
    logic [DropBits-1:0]    dropped_total;
  } res_t;

  typedef struct packed {
    logic [StateBits-1:0]   prev_state;
    logic [StateBits-1:0]   cur_state;
    logic [StampBits-1:0]   stamp;
  } rec_t;

endpackage

// File: hdl/transition_trace_overwrite_queue_unit.sv
// Transition trace queue with overwrite of the oldest record.
//
// A request is presented on req_i and taken at a rising edge where start is
// high and busy is low. The block never stalls, so busy stays low and one
// request can be taken in every cycle. The opcode selects a push, a pop, a
// clear or no operation. A push into a full queue overwrites the oldest
// record and counts one dropped record.
//
// Each request yields exactly one result on res_o, marked by done_o for a
// single cycle, in the cycle after the request was taken. The result latency is
// set by the registered read port of the record memory. The receiver cannot
// hold results off; back-to-back requests give back-to-back results.
//
// Reset empties the queue and zeroes the dropped count. The record memory is
// not cleared, since only entries written by a push can ever be popped.
`include "transition_trace_overwrite_queue_unit_defines.svh"

module transition_trace_overwrite_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ttoq_pkg::req_t req_i,
  output logic           done_o,
  output ttoq_pkg::res_t res_o
);
  import ttoq_pkg::*;

  localparam int unsigned IdxW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FullCnt = FillW'(QUEUE_DEPTH);

  rec_t mem_q [QUEUE_DEPTH];
  rec_t rd_q;

  logic [IdxW-1:0]     head_q, head_d;
  logic [IdxW-1:0]     tail_q, tail_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [DropBits-1:0] drop_q, drop_d;
  logic                done_q;
  logic                pop_ok_q, pop_ok_d;
  logic                accept;
  logic                do_push;
  logic                do_pop;
  logic [IdxW-1:0]     head_nxt;
  logic [IdxW-1:0]     tail_nxt;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign do_push  = accept && (req_i.opcode == OpPush);
  assign do_pop   = accept && (req_i.opcode == OpPop) && (fill_q != '0);
  assign head_nxt = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    drop_d   = drop_q;
    pop_ok_d = 1'b0;
    if (accept) begin
      unique case (req_i.opcode)
        OpPush: begin
          head_d = head_nxt;
          if (fill_q != FullCnt) begin
            fill_d = fill_q + 1'b1;
          end else begin
            tail_d = tail_nxt;
            drop_d = drop_q + 1'b1;
          end
        end
        OpPop: begin
          if (fill_q != '0) begin
            tail_d   = tail_nxt;
            fill_d   = fill_q - 1'b1;
            pop_ok_d = 1'b1;
          end
        end
        OpClear: begin
          head_d = '0;
          tail_d = '0;
          fill_d = '0;
          drop_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[head_q] <= '{prev_state: req_i.prev_state_in,
                         cur_state:  req_i.cur_state_in,
                         stamp:      req_i.stamp_in};
    end
    if (do_pop) begin
      rd_q <= mem_q[tail_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      drop_q   <= '0;
      done_q   <= 1'b0;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      done_q   <= accept;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_comb begin
    res_o               = '0;
    res_o.pop_valid     = pop_ok_q;
    res_o.dropped_total = drop_q;
    if (pop_ok_q) begin
      res_o.prev_state_out = rd_q.prev_state;
      res_o.cur_state_out  = rd_q.cur_state;
      res_o.stamp_out      = rd_q.stamp;
    end
  end

  assign done_o = done_q;

  `TTOQ_ASSERT_NEVER(a_fill_bound, fill_q > FullCnt, "Fill count exceeds the queue depth.")
  `TTOQ_ASSERT(a_ptr_match, ((fill_q == '0) || (fill_q == FullCnt)) |-> (head_q == tail_q), "Head and tail disagree for an empty or full queue.")
  `TTOQ_ASSERT(a_pop_fill, (done_o && res_o.pop_valid) |-> (fill_q == $past(fill_q) - 1'b1), "A returned record did not lower the fill count.")
  `TTOQ_ASSERT(a_drop_step, (drop_q != $past(drop_q)) |-> ((drop_q == $past(drop_q) + 1'b1) || (drop_q == '0)), "Dropped count moved by other than one or a clear.")

endmodule
